FILE: hdl/mpq_pkg.sv
// Shared types and constants for the max-priority queue.
package mpq_pkg;

  localparam int FUNC_W    = 2;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int CAP_W     = 5;
  localparam int OUT_CNT_W = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;     // latch the incoming word
    logic eval;       // latch the status code
    logic enq_write;  // append the value
    logic scan_start; // begin reading slots from zero
    logic move;       // move the last entry into the vacated slot
    logic load_out;   // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic enq_ok;
    logic is_peek;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/mpq_ctrl.sv
// Controller state machine for the max-priority queue.
module mpq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  mpq_pkg::stat_t stat,
  output mpq_pkg::cmd_t  cmd
);
  import mpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_SCAN, S_LAST, S_MOVE, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.enq_write = stat.enq_ok;
          state_nxt     = S_RESP;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = stat.is_peek ? S_RESP : S_LAST;
        end
      end
      // wait for the last entry to come out of the store
      S_LAST: begin
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded while previous word still waits");

  a_scan_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.scan_done && stat.is_peek) |=> state_r == S_RESP)
    else $error("peek did not go to response after scan");

endmodule

FILE: hdl/mpq_dp.sv
// Datapath for the max-priority queue: entry store, scan comparator, result register.
module mpq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpq_pkg::cmd_t                 cmd,
  output mpq_pkg::stat_t                stat,
  input  logic [mpq_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          cfg_valid,
  input  logic [mpq_pkg::CAP_W-1:0]     cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mpq_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mpq_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = CNT_W + CAP_W;
  localparam int PAD_W = OUT_DATA_W - (STATUS_W + VAL_W + OUT_CNT_W + 2);

  logic [VAL_W-1:0]    mem [DEPTH];
  logic [VAL_W-1:0]    rdata_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic [VAL_W-1:0]    wr_data;

  logic [FUNC_W-1:0]   op_r;
  logic [VAL_W-1:0]    val_r;
  logic [CNT_W-1:0]    occ_r;
  logic [CAP_W-1:0]    cap_r;
  logic [STATUS_W-1:0] st_r;
  logic                hit_r;

  logic                scan_act_r;
  logic [AW-1:0]       rd_idx_r;
  logic                pend_vld_r;
  logic [AW-1:0]       pend_idx_r;
  logic [VAL_W-1:0]    best_r;
  logic [AW-1:0]       best_slot_r;

  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                empty, full, is_enq, is_qry;
  logic [AW-1:0]       last_idx;
  logic                take_new;
  logic [VAL_W-1:0]    res_val;

  // decode the held operation against the store state
  always_comb begin
    empty    = (occ_r == '0);
    full     = (CMP_W'(occ_r) >= CMP_W'(cap_r)) || (CMP_W'(occ_r) >= CMP_W'(DEPTH));
    is_enq   = (op_r == FUNC_ENQ);
    is_qry   = (op_r == FUNC_DEQ) || (op_r == FUNC_PEEK);
    last_idx = AW'(occ_r - 1'b1);
    take_new = (pend_idx_r == '0) || ($signed(rdata_r) > $signed(best_r));
    res_val  = hit_r ? best_r : '0;
  end

  always_comb begin
    stat.need_scan = is_qry && !empty;
    stat.enq_ok    = is_enq && !full;
    stat.is_peek   = (op_r == FUNC_PEEK);
    stat.scan_done = pend_vld_r && (pend_idx_r == last_idx);
    stat.out_free  = !out_valid_r || out_tready;
  end

  // select store port addresses and write data
  always_comb begin
    rd_addr = scan_act_r ? rd_idx_r : last_idx;
    mem_we  = cmd.enq_write || cmd.move;
    wr_addr = cmd.move ? best_slot_r : AW'(occ_r);
    wr_data = cmd.move ? rdata_r : val_r;
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // control state: count, capacity, scan sequencing, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      scan_act_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (cmd.enq_write) begin
        occ_r <= occ_r + 1'b1;
      end else if (cmd.move) begin
        occ_r <= occ_r - 1'b1;
      end
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
      end else if (scan_act_r && rd_idx_r == last_idx) begin
        scan_act_r <= 1'b0;
      end
      pend_vld_r <= scan_act_r;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: held word, scan index, running maximum, result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_tdata[FUNC_W-1:0];
      val_r <= in_tdata[FUNC_W +: VAL_W];
    end
    if (cmd.eval) begin
      hit_r <= is_qry && !empty;
      if (is_enq && full) begin
        st_r <= STATUS_FULL;
      end else if (is_qry && empty) begin
        st_r <= STATUS_EMPTY;
      end else begin
        st_r <= STATUS_OK;
      end
    end
    if (cmd.scan_start) begin
      rd_idx_r <= '0;
    end else if (scan_act_r) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    pend_idx_r <= rd_idx_r;
    // keep the first slot on ties by taking only a strictly larger value
    if (pend_vld_r && take_new) begin
      best_r      <= rdata_r;
      best_slot_r <= pend_idx_r;
    end
    if (cmd.load_out) begin
      out_data_r <= {{PAD_W{1'b0}}, full, empty, OUT_CNT_W'(occ_r), res_val, st_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(occ_r) <= CMP_W'(DEPTH))
    else $error("occupancy above store depth");

  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |-> (occ_r != '0) && $past(stat.scan_done, 2))
    else $error("move without a finished scan");

endmodule

FILE: hdl/max_priority_queue_linear_scan.sv
// Top level of the unsorted-store max-priority queue.
//
//  channel | direction | word contents (low bit first)
//  in_     | slave     | func[1:0], value[33:2], zero pad to 40 bits
//  out_    | master    | status[1:0], result_value[33:2], entry_count[38:34],
//          |           | is_empty[39], is_full[40], zero pad to 48 bits
//  cfg_    | slave     | capacity_limit[4:0], always ready
//
// Enqueue, failed operations and unused codes go from evaluate straight to the result.
// Dequeue scans the stored slots, then moves the last entry into the vacated slot;
// peek only scans. One store read port feeds a single comparator, one slot a cycle.
// Reset clears the count, sets capacity to 16 and drops any pending result.
// A new word is taken while a result still waits in the output register.
module max_priority_queue_linear_scan #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mpq_pkg::IN_DATA_W-1:0]  in_tdata,   // func, value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mpq_pkg::OUT_DATA_W-1:0] out_tdata,  // status, result_value,
                                                     // entry_count, is_empty, is_full
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpq_pkg::CAP_W-1:0]      cfg_data    // capacity_limit
);
  import mpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
